[design/i2cmbe_pkg.sv]
package i2cmbe_pkg;

	// bits per byte on the bus
	localparam int unsigned NBITS = 8;

	// phase length after reset
	localparam logic [15:0] TPP_RESET = 16'd100;

	// command codes
	localparam logic [1:0] CMD_START = 2'd0;
	localparam logic [1:0] CMD_STOP  = 2'd1;
	localparam logic [1:0] CMD_WRITE = 2'd2;
	localparam logic [1:0] CMD_READ  = 2'd3;

	// bus sequencer phases, each one waiting for the next edge group
	typedef enum logic [3:0] {
		PH_IDLE,
		PH_START_SDA,
		PH_START_SCL,
		PH_STOP_SDA,
		PH_WR_HIGH,
		PH_WR_LOW,
		PH_WR_ACKREL,
		PH_WR_ACKSMP,
		PH_RD_SAMP,
		PH_RD_HIGH,
		PH_RD_ACKDRV,
		PH_RD_ACKHI,
		PH_RD_ACKLO
	} phase_t;

	// one input beat
	typedef struct packed {
		logic       cmd_valid;
		logic [1:0] cmd;
		logic [7:0] tx_byte;
		logic       send_ack;
		logic       sda_in;
	} item_t;

	// one result beat
	typedef struct packed {
		logic       scl_out;
		logic       sda_out;
		logic       busy_res;
		logic       done_res;
		logic [7:0] rx_byte;
		logic       ack_seen;
	} result_t;

	// msb-first bit of a byte at a bit position
	function automatic logic tx_bit(input logic [7:0] b, input logic [3:0] idx);
		logic [2:0] pos;
		pos = 3'd7 - idx[2:0];
		return b[pos];
	endfunction

endpackage

[design/i2cmbe_in_reg.sv]
module i2cmbe_in_reg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [15:0]         s_tdata,  // tx_byte[7:0], send_ack[8], sda_in[9], zero
	input  logic [2:0]          s_tuser,  // cmd_valid[0], cmd[2:1]
	input  logic                adv,
	output logic                valid_s1,
	output i2cmbe_pkg::item_t   item_s1
);
	import i2cmbe_pkg::*;

	logic take;

	// the stage moves on when downstream can take it
	assign take     = valid_s1 && adv;
	assign s_tready = !valid_s1 || adv;

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	// beat payload
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.cmd_valid <= s_tuser[0];
			item_s1.cmd       <= s_tuser[2:1];
			item_s1.tx_byte   <= s_tdata[7:0];
			item_s1.send_ack  <= s_tdata[8];
			item_s1.sda_in    <= s_tdata[9];
		end
	end

endmodule

[design/i2cmbe_step.sv]
module i2cmbe_step (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  i2cmbe_pkg::item_t   item,
	input  logic [15:0]         tpp,
	output i2cmbe_pkg::result_t res
);
	import i2cmbe_pkg::*;

	phase_t      phase_q, phase_d;
	logic [3:0]  bit_q, bit_d, bit_inc;
	logic [7:0]  shift_q, shift_d;
	logic [15:0] tick_q, tick_d;
	logic        scl_q, scl_d;
	logic        sda_q, sda_d;
	logic        ack_q, ack_d;
	logic        ack_tx_q, ack_tx_d;
	logic [7:0]  rx_q, rx_d;
	logic [7:0]  txh_q, txh_d;
	logic [15:0] period;
	logic [16:0] tick_nxt;
	logic        fire;
	logic        done;
	logic        start;

	// phase timer: zero length acts as one
	assign period   = (tpp == 16'd0) ? 16'd1 : tpp;
	assign tick_nxt = {1'b0, tick_q} + 17'd1;
	assign fire     = (phase_q != PH_IDLE) && (tick_nxt >= {1'b0, period});
	assign start    = (phase_q == PH_IDLE) && item.cmd_valid;
	assign bit_inc  = bit_q + 4'd1;

	// next phase and done pulse
	always_comb begin
		phase_d = phase_q;
		done    = 1'b0;
		if (en && start) begin
			unique case (item.cmd)
				CMD_START: phase_d = PH_START_SDA;
				CMD_STOP:  phase_d = PH_STOP_SDA;
				CMD_WRITE: phase_d = PH_WR_HIGH;
				CMD_READ:  phase_d = PH_RD_SAMP;
				default:   phase_d = PH_IDLE;
			endcase
		end else if (en && fire) begin
			unique case (phase_q)
				PH_START_SDA: phase_d = PH_START_SCL;
				PH_START_SCL: begin
					phase_d = PH_IDLE;
					done    = 1'b1;
				end
				PH_STOP_SDA: begin
					phase_d = PH_IDLE;
					done    = 1'b1;
				end
				PH_WR_HIGH:   phase_d = PH_WR_LOW;
				PH_WR_LOW:    phase_d = (bit_inc < 4'(NBITS)) ? PH_WR_HIGH : PH_WR_ACKREL;
				PH_WR_ACKREL: phase_d = PH_WR_ACKSMP;
				PH_WR_ACKSMP: begin
					phase_d = PH_IDLE;
					done    = 1'b1;
				end
				PH_RD_SAMP:   phase_d = (bit_inc < 4'(NBITS)) ? PH_RD_HIGH : PH_RD_ACKDRV;
				PH_RD_HIGH:   phase_d = PH_RD_SAMP;
				PH_RD_ACKDRV: phase_d = PH_RD_ACKHI;
				PH_RD_ACKHI:  phase_d = PH_RD_ACKLO;
				PH_RD_ACKLO: begin
					phase_d = PH_IDLE;
					done    = 1'b1;
				end
				default:      phase_d = PH_IDLE;
			endcase
		end
	end

	// line levels, counters and data registers
	always_comb begin
		bit_d    = bit_q;
		shift_d  = shift_q;
		tick_d   = tick_q;
		scl_d    = scl_q;
		sda_d    = sda_q;
		ack_d    = ack_q;
		ack_tx_d = ack_tx_q;
		rx_d     = rx_q;
		txh_d    = txh_q;
		if (en && start) begin
			tick_d = 16'd0;
			bit_d  = 4'd0;
			unique case (item.cmd)
				CMD_START: begin
					sda_d = 1'b1;
					scl_d = 1'b1;
				end
				CMD_STOP: begin
					sda_d = 1'b0;
					scl_d = 1'b1;
				end
				CMD_WRITE: begin
					txh_d = item.tx_byte;
					sda_d = item.tx_byte[7];
				end
				default: begin
					ack_tx_d = item.send_ack;
					shift_d  = 8'd0;
					sda_d    = 1'b1;
					scl_d    = 1'b1;
				end
			endcase
		end else if (en && phase_q != PH_IDLE) begin
			if (fire) begin
				tick_d = 16'd0;
				unique case (phase_q)
					PH_START_SDA: sda_d = 1'b0;
					PH_START_SCL: scl_d = 1'b0;
					PH_STOP_SDA:  sda_d = 1'b1;
					PH_WR_HIGH:   scl_d = 1'b1;
					PH_WR_LOW: begin
						scl_d = 1'b0;
						bit_d = bit_inc;
						if (bit_inc < 4'(NBITS)) begin
							sda_d = tx_bit(txh_q, bit_inc);
						end
					end
					PH_WR_ACKREL: begin
						sda_d = 1'b1;
						scl_d = 1'b1;
					end
					PH_WR_ACKSMP: begin
						ack_d = !item.sda_in;
						scl_d = 1'b0;
					end
					PH_RD_SAMP: begin
						shift_d = {shift_q[6:0], item.sda_in};
						scl_d   = 1'b0;
						bit_d   = bit_inc;
					end
					PH_RD_HIGH:   scl_d = 1'b1;
					PH_RD_ACKDRV: sda_d = !ack_tx_q;
					PH_RD_ACKHI:  scl_d = 1'b1;
					PH_RD_ACKLO: begin
						scl_d = 1'b0;
						rx_d  = shift_q;
					end
					default: ;
				endcase
			end else begin
				tick_d = tick_nxt[15:0];
			end
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			bit_q    <= 4'd0;
			shift_q  <= 8'd0;
			tick_q   <= 16'd0;
			scl_q    <= 1'b1;
			sda_q    <= 1'b1;
			ack_q    <= 1'b0;
			ack_tx_q <= 1'b0;
			rx_q     <= 8'd0;
			txh_q    <= 8'd0;
		end else begin
			phase_q  <= phase_d;
			bit_q    <= bit_d;
			shift_q  <= shift_d;
			tick_q   <= tick_d;
			scl_q    <= scl_d;
			sda_q    <= sda_d;
			ack_q    <= ack_d;
			ack_tx_q <= ack_tx_d;
			rx_q     <= rx_d;
			txh_q    <= txh_d;
		end
	end

	// result of this beat, taken from the updated state
	always_comb begin
		res.scl_out  = scl_d;
		res.sda_out  = sda_d;
		res.busy_res = (phase_d != PH_IDLE);
		res.done_res = done;
		res.rx_byte  = rx_d;
		res.ack_seen = ack_d;
	end

endmodule

[design/i2cmbe_out_reg.sv]
module i2cmbe_out_reg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  i2cmbe_pkg::result_t res,
	output logic                adv,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [15:0]         m_tdata  // scl_out[0], sda_out[1], busy_res[2], done_res[3],
	                                     // rx_byte[11:4], ack_seen[12], zero
);
	import i2cmbe_pkg::*;

	result_t res_q;

	// the result register can take a beat when empty or being drained
	assign adv = !m_tvalid || m_tready;

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (load) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	// pack the result beat
	assign m_tdata = {3'd0, res_q.ack_seen, res_q.rx_byte, res_q.done_res,
		res_q.busy_res, res_q.sda_out, res_q.scl_out};

endmodule

[design/i2c_master_bit_engine.sv]
// Bit-level I2C master. Every input beat stands for one tick of bus timing and
// may carry a command (start, stop, write byte, read byte with ACK or NACK)
// together with the sampled SDA level. Every input beat yields exactly one
// result beat with the SCL and SDA drive levels (1 = released), busy, a done
// pulse, the last received byte and the last write's ACK.
// Commands offered while a sequence is running are dropped.
// cfg_wr_en / cfg_wr_data set the ticks per bus phase (reset 100, 0 acts as
// 1); write it only while the engine is idle.
// A beat accepted into the input register is processed and loaded into the
// result register as soon as that register has room, and m_tvalid rises.
// Throughput is one beat per cycle while m_tready stays high; the state update
// between the input register and the result register is a single short pass.
// Reset: both lines released, sequencer idle, received byte and ACK zero.
// When m_tready is low the result register holds its beat and the input
// register can still take one more beat; s_tready then drops until the
// result is taken, and nothing is lost or repeated.
module i2c_master_bit_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,  // ticks_per_phase
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,      // tx_byte[7:0], send_ack[8], sda_in[9], zero
	input  logic [2:0]  s_tuser,      // cmd_valid[0], cmd[2:1]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata       // scl_out[0], sda_out[1], busy_res[2], done_res[3],
	                                  // rx_byte[11:4], ack_seen[12], zero
);
	import i2cmbe_pkg::*;

	logic        valid_s1;
	item_t       item_s1;
	result_t     res;
	logic        adv;
	logic        en;
	logic [15:0] tpp_q;

	// phase length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpp_q <= TPP_RESET;
		end else if (cfg_wr_en) begin
			tpp_q <= cfg_wr_data;
		end
	end

	// one beat steps the sequencer when the result register has room
	assign en = valid_s1 && adv;

	i2cmbe_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.adv      (adv),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	i2cmbe_step u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.item   (item_s1),
		.tpp    (tpp_q),
		.res    (res)
	);

	i2cmbe_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (en),
		.res      (res),
		.adv      (adv),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

[bench/tb_i2c_master_bit_engine.sv]
`timescale 1ns / 1ps

module tb_i2c_master_bit_engine;
	import i2cmbe_pkg::*;

	localparam int STALL_LIMIT = 20000;
	localparam int MAX_REPORTS = 30;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [15:0] cfg_wr_data = 16'd0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = 16'd0;  // tx_byte[7:0], send_ack[8], sda_in[9], zero
	logic [2:0]  s_tuser = 3'd0;   // cmd_valid[0], cmd[2:1]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;          // scl_out[0], sda_out[1], busy_res[2], done_res[3],
	                               // rx_byte[11:4], ack_seen[12], zero

	// bus model state, updated once per accepted tick
	phase_t      bus_phase = PH_IDLE;
	logic [3:0]  bit_pos = 4'd0;
	logic [7:0]  rx_shift = 8'd0;
	logic [15:0] tick_cnt = 16'd0;
	logic        scl_lvl = 1'b1;
	logic        sda_lvl = 1'b1;
	logic        ack_lvl = 1'b0;
	logic        ack_drive = 1'b0;
	logic [7:0]  rx_hold = 8'd0;
	logic [7:0]  tx_hold = 8'd0;
	logic [15:0] phase_len = TPP_RESET;

	result_t     bus_levels_q[$];
	int          errors = 0;
	int          ticks_sent = 0;
	int          results_checked = 0;
	int          cmd_issued[4] = '{0, 0, 0, 0};
	int          tx_gap_pct = 0;
	int          rx_stall_pct = 0;
	int          quiet_cycles = 0;

	i2c_master_bit_engine dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	// 50 MHz clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// one bus tick: start a command when idle, else count down to the next edge group
	function automatic result_t bus_tick(input item_t it);
		result_t     r;
		logic [16:0] next_cnt;
		logic [15:0] period;
		logic        fin;
		period = (phase_len == 16'd0) ? 16'd1 : phase_len;
		fin = 1'b0;
		if (bus_phase == PH_IDLE) begin
			if (it.cmd_valid) begin
				tick_cnt = 16'd0;
				bit_pos = 4'd0;
				cmd_issued[it.cmd]++;
				case (it.cmd)
					CMD_START: begin
						sda_lvl = 1'b1;
						scl_lvl = 1'b1;
						bus_phase = PH_START_SDA;
					end
					CMD_STOP: begin
						sda_lvl = 1'b0;
						scl_lvl = 1'b1;
						bus_phase = PH_STOP_SDA;
					end
					CMD_WRITE: begin
						tx_hold = it.tx_byte;
						sda_lvl = it.tx_byte[7];
						bus_phase = PH_WR_HIGH;
					end
					default: begin
						ack_drive = it.send_ack;
						rx_shift = 8'd0;
						sda_lvl = 1'b1;
						scl_lvl = 1'b1;
						bus_phase = PH_RD_SAMP;
					end
				endcase
			end
		end else begin
			next_cnt = {1'b0, tick_cnt} + 17'd1;
			if (next_cnt >= {1'b0, period}) begin
				tick_cnt = 16'd0;
				case (bus_phase)
					PH_START_SDA: begin
						sda_lvl = 1'b0;
						bus_phase = PH_START_SCL;
					end
					PH_START_SCL: begin
						scl_lvl = 1'b0;
						bus_phase = PH_IDLE;
						fin = 1'b1;
					end
					PH_STOP_SDA: begin
						sda_lvl = 1'b1;
						bus_phase = PH_IDLE;
						fin = 1'b1;
					end
					PH_WR_HIGH: begin
						scl_lvl = 1'b1;
						bus_phase = PH_WR_LOW;
					end
					PH_WR_LOW: begin
						scl_lvl = 1'b0;
						bit_pos = bit_pos + 4'd1;
						if (bit_pos < NBITS) begin
							sda_lvl = tx_hold[3'd7 - bit_pos[2:0]];
							bus_phase = PH_WR_HIGH;
						end else begin
							bus_phase = PH_WR_ACKREL;
						end
					end
					PH_WR_ACKREL: begin
						sda_lvl = 1'b1;
						scl_lvl = 1'b1;
						bus_phase = PH_WR_ACKSMP;
					end
					PH_WR_ACKSMP: begin
						ack_lvl = ~it.sda_in;
						scl_lvl = 1'b0;
						bus_phase = PH_IDLE;
						fin = 1'b1;
					end
					PH_RD_SAMP: begin
						rx_shift = {rx_shift[6:0], it.sda_in};
						scl_lvl = 1'b0;
						bit_pos = bit_pos + 4'd1;
						bus_phase = (bit_pos < NBITS) ? PH_RD_HIGH : PH_RD_ACKDRV;
					end
					PH_RD_HIGH: begin
						scl_lvl = 1'b1;
						bus_phase = PH_RD_SAMP;
					end
					PH_RD_ACKDRV: begin
						sda_lvl = ~ack_drive;
						bus_phase = PH_RD_ACKHI;
					end
					PH_RD_ACKHI: begin
						scl_lvl = 1'b1;
						bus_phase = PH_RD_ACKLO;
					end
					PH_RD_ACKLO: begin
						scl_lvl = 1'b0;
						rx_hold = rx_shift;
						bus_phase = PH_IDLE;
						fin = 1'b1;
					end
					default: begin
						bus_phase = PH_IDLE;
					end
				endcase
			end else begin
				tick_cnt = next_cnt[15:0];
			end
		end
		r.scl_out = scl_lvl;
		r.sda_out = sda_lvl;
		r.busy_res = (bus_phase != PH_IDLE);
		r.done_res = fin;
		r.rx_byte = rx_hold;
		r.ack_seen = ack_lvl;
		return r;
	endfunction

	function automatic item_t make_item(input logic valid, input logic [1:0] c,
			input logic [7:0] b, input logic ack, input logic sda);
		item_t it;
		it.cmd_valid = valid;
		it.cmd = c;
		it.tx_byte = b;
		it.send_ack = ack;
		it.sda_in = sda;
		return it;
	endfunction

	// sda_sel 0 or 1 holds the line, anything else randomizes it
	function automatic logic pick_sda(input int sda_sel);
		logic v;
		v = (sda_sel > 1) ? logic'($urandom_range(1)) : logic'(sda_sel[0]);
		return v;
	endfunction

	task automatic report_mismatch(input string msg);
		errors++;
		if (errors <= MAX_REPORTS)
			$display("[%0t] mismatch: %s", $time, msg);
	endtask

	// offer one tick beat, wait for it to be taken, then predict its result
	task automatic send_tick(input item_t it);
		while ($urandom_range(99) < tx_gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= {it.cmd, it.cmd_valid};
		s_tdata <= {6'd0, it.sda_in, it.send_ack, it.tx_byte};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		bus_levels_q.push_back(bus_tick(it));
		ticks_sent++;
	endtask

	// ticks until the sequencer is idle, with commands thrown in while busy
	task automatic finish_sequence(input int junk_pct, input int sda_sel);
		while (bus_phase != PH_IDLE)
			send_tick(make_item($urandom_range(99) < junk_pct, 2'($urandom_range(3)),
				8'($urandom_range(255)), 1'($urandom_range(1)), pick_sda(sda_sel)));
	endtask

	task automatic run_command(input logic [1:0] c, input logic [7:0] b, input logic ack,
			input int junk_pct, input int sda_sel);
		send_tick(make_item(1'b1, c, b, ack, pick_sda(sda_sel)));
		finish_sequence(junk_pct, sda_sel);
	endtask

	// stop sending and wait until every predicted beat has come back
	task automatic drain_results();
		s_tvalid <= 1'b0;
		do
			@(negedge clk);
		while (bus_levels_q.size() != 0);
		repeat (4) @(negedge clk);
		@(posedge clk);
	endtask

	// register write with the sequencer idle and the pipeline empty
	task automatic set_phase_len(input logic [15:0] v);
		finish_sequence(0, 2);
		drain_results();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		phase_len = v;
		cfg_wr_en <= 1'b0;
	endtask

	// idle ticks after reset hold the lines, then one start at the reset phase length
	task automatic test_reset_timing();
		repeat (4)
			send_tick(make_item(1'b0, 2'($urandom_range(3)), 8'($urandom_range(255)),
				1'($urandom_range(1)), 1'($urandom_range(1))));
		run_command(CMD_START, 8'h00, 1'b0, 0, 2);
	endtask

	// zero phase length runs as one; data and ack extremes on writes and reads
	task automatic test_zero_phase_len();
		set_phase_len(16'd0);
		run_command(CMD_START, 8'h00, 1'b0, 0, 2);
		run_command(CMD_WRITE, 8'hFF, 1'b0, 0, 0);
		run_command(CMD_WRITE, 8'h00, 1'b0, 0, 1);
		run_command(CMD_READ, 8'h00, 1'b1, 0, 1);
		run_command(CMD_READ, 8'hFF, 1'b0, 0, 0);
		run_command(CMD_STOP, 8'h00, 1'b0, 0, 2);
	endtask

	// commands offered on every busy tick, the finishing one included, are dropped
	task automatic test_busy_commands();
		set_phase_len(16'd1);
		run_command(CMD_WRITE, 8'hA5, 1'b1, 100, 2);
		run_command(CMD_READ, 8'h5A, 1'b1, 100, 2);
		run_command(CMD_STOP, 8'hC3, 1'b0, 100, 2);
	endtask

	task automatic random_transaction(input int junk_pct);
		int n;
		run_command(CMD_START, 8'($urandom_range(255)), 1'($urandom_range(1)), junk_pct, 2);
		run_command(CMD_WRITE, 8'($urandom_range(255)), 1'($urandom_range(1)), junk_pct, 2);
		n = $urandom_range(3);
		repeat (n) begin
			if ($urandom_range(1))
				run_command(CMD_WRITE, 8'($urandom_range(255)), 1'($urandom_range(1)),
					junk_pct, 2);
			else
				run_command(CMD_READ, 8'($urandom_range(255)), 1'($urandom_range(1)),
					junk_pct, 2);
		end
		run_command(CMD_STOP, 8'($urandom_range(255)), 1'($urandom_range(1)), junk_pct, 2);
	endtask

	// mostly well-formed transactions, some stray commands and quiet ticks
	task automatic test_random_traffic(input int n_ticks, input int tx_gap, input int rx_stall);
		int stop_at;
		int next_cfg_at;
		int sel;
		tx_gap_pct = tx_gap;
		rx_stall_pct = rx_stall;
		stop_at = ticks_sent + n_ticks;
		next_cfg_at = ticks_sent;
		while (ticks_sent < stop_at) begin
			if (ticks_sent >= next_cfg_at) begin
				sel = $urandom_range(99);
				if (sel < 50)
					set_phase_len(16'd1);
				else if (sel < 85)
					set_phase_len(16'($urandom_range(3, 2)));
				else
					set_phase_len(16'($urandom_range(9, 4)));
				next_cfg_at = ticks_sent + 150;
			end
			sel = $urandom_range(99);
			if (sel < 80) begin
				random_transaction(15);
			end else if (sel < 92) begin
				run_command(2'($urandom_range(3)), 8'($urandom_range(255)),
					1'($urandom_range(1)), 30, 2);
			end else begin
				repeat ($urandom_range(20, 3))
					send_tick(make_item(1'b0, 2'($urandom_range(3)),
						8'($urandom_range(255)), 1'($urandom_range(1)),
						1'($urandom_range(1))));
			end
			if ($urandom_range(9) == 0)
				drain_results();
		end
	endtask

	// longest phase length: a start holds its first edge for the whole stretch
	task automatic test_long_phase();
		set_phase_len(16'hFFFF);
		send_tick(make_item(1'b1, CMD_START, 8'h00, 1'b0, 1'b1));
		repeat (60)
			send_tick(make_item(1'($urandom_range(1)), 2'($urandom_range(3)),
				8'($urandom_range(255)), 1'($urandom_range(1)), 1'($urandom_range(1))));
	endtask

	// receiver back-pressure
	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= rx_stall_pct);

	// compare each result beat with the oldest prediction
	always @(posedge clk) begin
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (bus_levels_q.size() == 0) begin
				report_mismatch($sformatf("result beat 0x%04h with nothing expected", m_tdata));
			end else begin
				want = bus_levels_q.pop_front();
				results_checked++;
				if (m_tdata[0] !== want.scl_out)
					report_mismatch($sformatf("result %0d scl_out %b want %b",
						results_checked, m_tdata[0], want.scl_out));
				if (m_tdata[1] !== want.sda_out)
					report_mismatch($sformatf("result %0d sda_out %b want %b",
						results_checked, m_tdata[1], want.sda_out));
				if (m_tdata[2] !== want.busy_res)
					report_mismatch($sformatf("result %0d busy_res %b want %b",
						results_checked, m_tdata[2], want.busy_res));
				if (m_tdata[3] !== want.done_res)
					report_mismatch($sformatf("result %0d done_res %b want %b",
						results_checked, m_tdata[3], want.done_res));
				if (m_tdata[11:4] !== want.rx_byte)
					report_mismatch($sformatf("result %0d rx_byte 0x%02h want 0x%02h",
						results_checked, m_tdata[11:4], want.rx_byte));
				if (m_tdata[12] !== want.ack_seen)
					report_mismatch($sformatf("result %0d ack_seen %b want %b",
						results_checked, m_tdata[12], want.ack_seen));
			end
		end
	end

	// watchdog on cycles with no beat moving on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("watchdog: no beat moved for %0d cycles", STALL_LIMIT);
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_timing();
		test_zero_phase_len();
		test_busy_commands();
		test_random_traffic(320, 9, 88);
		test_random_traffic(320, 88, 9);
		test_random_traffic(330, 0, 0);
		test_long_phase();

		drain_results();
		repeat (8) @(negedge clk);
		$display("%0d ticks sent, %0d result beats checked, phase lengths 0 to 65535",
			ticks_sent, results_checked);
		$display("commands run: start %0d, stop %0d, write %0d, read %0d",
			cmd_issued[CMD_START], cmd_issued[CMD_STOP], cmd_issued[CMD_WRITE],
			cmd_issued[CMD_READ]);
		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d mismatches", errors);
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
